// File: rtl/core/ltcc_pkg.sv
// ----------------------------------------------------------------------------
// ltcc_pkg
// Shared types and codes for the link target containment check.
// ----------------------------------------------------------------------------
package ltcc_pkg;

  localparam int PARENT_LIMIT_DEF = 4096;
  localparam int DEPTH_BITS_DEF   = 16;

  // item modes
  localparam logic [1:0] MODE_ENTRY_CHAR = 2'd0;
  localparam logic [1:0] MODE_ENTRY_END  = 2'd1;
  localparam logic [1:0] MODE_TGT_CHAR   = 2'd2;
  localparam logic [1:0] MODE_TGT_END    = 2'd3;

  // component classes
  localparam logic [1:0] CLS_EMPTY  = 2'd0;
  localparam logic [1:0] CLS_DOT    = 2'd1;
  localparam logic [1:0] CLS_DOTDOT = 2'd2;
  localparam logic [1:0] CLS_OTHER  = 2'd3;

  // verdict reasons
  localparam logic [2:0] RSN_OK        = 3'd0;
  localparam logic [2:0] RSN_EMPTY     = 3'd1;
  localparam logic [2:0] RSN_BACKSLASH = 3'd2;
  localparam logic [2:0] RSN_ESCAPE    = 3'd3;
  localparam logic [2:0] RSN_TOO_LONG  = 3'd4;

  localparam logic [7:0] CH_SLASH     = 8'h2f;
  localparam logic [7:0] CH_BACKSLASH = 8'h5c;
  localparam logic [7:0] CH_DOT       = 8'h2e;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] ch;
  } item_t;

  typedef struct packed {
    logic       accepted;
    logic [2:0] reason;
  } result_t;

  function automatic logic [1:0] next_class(input logic [1:0] cls, input logic [7:0] c);
    logic [1:0] r;
    r = CLS_OTHER;
    if (c == CH_DOT) begin
      if (cls == CLS_EMPTY) r = CLS_DOT;
      else if (cls == CLS_DOT) r = CLS_DOTDOT;
    end
    return r;
  endfunction

endpackage

// File: rtl/core/ltcc_walk.sv
// ----------------------------------------------------------------------------
// ltcc_walk
// Path walk state: depth counter, component class and flags; forms the
// verdict when the end of the target arrives.
// ----------------------------------------------------------------------------
module ltcc_walk #(
  parameter int PARENT_LIMIT = ltcc_pkg::PARENT_LIMIT_DEF,
  parameter int DEPTH_BITS   = ltcc_pkg::DEPTH_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  ltcc_pkg::item_t   item,
  output logic              res_valid,
  output ltcc_pkg::result_t res
);
  import ltcc_pkg::*;

  localparam int IDX_BITS = $clog2(PARENT_LIMIT + 1);
  localparam logic [IDX_BITS-1:0]   IDX_LIMIT = IDX_BITS'(PARENT_LIMIT);
  localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = '1;

  logic                  in_target, in_target_next;
  logic                  target_started, target_started_next;
  logic                  target_absolute, target_absolute_next;
  logic [1:0]            component_class, component_class_next;
  logic [DEPTH_BITS-1:0] dir_depth, dir_depth_next;
  logic                  escaped, escaped_next;
  logic                  saw_backslash, saw_backslash_next;
  logic [IDX_BITS-1:0]   char_index, char_index_next;
  logic                  parent_too_long, parent_too_long_next;

  logic [1:0]            cls_eff;      // class with last entry component dropped if needed
  logic [1:0]            cls_apply;
  logic [DEPTH_BITS-1:0] depth_base;
  logic                  esc_base;
  logic [DEPTH_BITS-1:0] depth_app;
  logic                  esc_app;
  logic                  fin_esc;

  // moving to the target drops the last entry component
  assign cls_eff = in_target ? component_class : CLS_EMPTY;

  always_comb begin
    cls_apply  = (item.mode == MODE_ENTRY_CHAR) ? component_class : cls_eff;
    depth_base = dir_depth;
    esc_base   = escaped;
    depth_app  = depth_base;
    esc_app    = esc_base;
    if (cls_apply == CLS_DOTDOT) begin
      if (depth_base == '0) esc_app = 1'b1;
      else depth_app = depth_base - 1'b1;
    end else if (cls_apply == CLS_OTHER) begin
      if (depth_base != DEPTH_MAX) depth_app = depth_base + 1'b1;
    end
  end

  always_comb begin
    in_target_next       = in_target;
    target_started_next  = target_started;
    target_absolute_next = target_absolute;
    component_class_next = component_class;
    dir_depth_next       = dir_depth;
    escaped_next         = escaped;
    saw_backslash_next   = saw_backslash;
    char_index_next      = char_index;
    parent_too_long_next = parent_too_long;
    fin_esc              = esc_app;
    res_valid            = 1'b0;
    res.accepted         = 1'b0;
    res.reason           = RSN_OK;
    unique case (item.mode)
      MODE_ENTRY_CHAR: begin
        if (!in_target) begin
          if (item.ch == CH_SLASH) begin
            if (char_index == IDX_LIMIT) parent_too_long_next = 1'b1;
            dir_depth_next       = depth_app;
            escaped_next         = esc_app;
            component_class_next = CLS_EMPTY;
          end else begin
            component_class_next = next_class(component_class, item.ch);
          end
          if (char_index != IDX_LIMIT) char_index_next = char_index + 1'b1;
        end
      end
      MODE_ENTRY_END: begin
        in_target_next       = 1'b1;
        component_class_next = cls_eff;
      end
      MODE_TGT_CHAR: begin
        in_target_next      = 1'b1;
        target_started_next = 1'b1;
        if (!target_started && item.ch == CH_SLASH) begin
          // leading slash: judged alone from the root
          target_absolute_next = 1'b1;
          dir_depth_next       = '0;
          escaped_next         = 1'b0;
          component_class_next = cls_eff;
        end else begin
          if (item.ch == CH_BACKSLASH) saw_backslash_next = 1'b1;
          if (item.ch == CH_SLASH) begin
            dir_depth_next       = depth_app;
            escaped_next         = esc_app;
            component_class_next = CLS_EMPTY;
          end else begin
            component_class_next = next_class(cls_eff, item.ch);
          end
        end
      end
      MODE_TGT_END: begin
        res_valid = take;
        priority if (!target_started)                   res.reason = RSN_EMPTY;
        else if (saw_backslash)                         res.reason = RSN_BACKSLASH;
        else if (!target_absolute && parent_too_long)   res.reason = RSN_TOO_LONG;
        else if (fin_esc)                               res.reason = RSN_ESCAPE;
        else                                            res.reason = RSN_OK;
        res.accepted         = (res.reason == RSN_OK);
        in_target_next       = 1'b0;
        target_started_next  = 1'b0;
        target_absolute_next = 1'b0;
        component_class_next = CLS_EMPTY;
        dir_depth_next       = '0;
        escaped_next         = 1'b0;
        saw_backslash_next   = 1'b0;
        char_index_next      = '0;
        parent_too_long_next = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_target       <= 1'b0;
      target_started  <= 1'b0;
      target_absolute <= 1'b0;
      component_class <= CLS_EMPTY;
      dir_depth       <= '0;
      escaped         <= 1'b0;
      saw_backslash   <= 1'b0;
      char_index      <= '0;
      parent_too_long <= 1'b0;
    end else if (take) begin
      in_target       <= in_target_next;
      target_started  <= target_started_next;
      target_absolute <= target_absolute_next;
      component_class <= component_class_next;
      dir_depth       <= dir_depth_next;
      escaped         <= escaped_next;
      saw_backslash   <= saw_backslash_next;
      char_index      <= char_index_next;
      parent_too_long <= parent_too_long_next;
    end
  end

  a_idx_sat: assert property (@(posedge clk) disable iff (rst) char_index <= IDX_LIMIT)
    else $error("entry index past limit");
  a_verdict_clears: assert property (@(posedge clk) disable iff (rst)
    take && item.mode == MODE_TGT_END |=> !in_target && dir_depth == '0 && !escaped)
    else $error("walk state not cleared after verdict");
  a_started_in_target: assert property (@(posedge clk) disable iff (rst)
    target_started |-> in_target)
    else $error("target started outside target");

endmodule

// File: rtl/core/link_target_containment_check.sv
// ----------------------------------------------------------------------------
// link_target_containment_check
// Checks that an archive link target stays beneath the extraction root.
// ----------------------------------------------------------------------------
//  channel | payload            | handshake
//  item    | mode, ch           | item_valid / item_stall
//  result  | accepted, reason   | result_valid / result_stall
//
//  One item per cycle while item_stall is low; the walk state updates in the
//  cycle a transaction is taken and the verdict is registered. A two-deep
//  result buffer (output register plus skid) lets items flow while a verdict
//  waits; item_stall rises only when both slots hold. Synchronous reset
//  clears the walk state and both slots.
// ----------------------------------------------------------------------------
module link_target_containment_check #(
  parameter int PARENT_LIMIT = ltcc_pkg::PARENT_LIMIT_DEF,
  parameter int DEPTH_BITS   = ltcc_pkg::DEPTH_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  ltcc_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output ltcc_pkg::result_t result
);
  import ltcc_pkg::*;

  logic    take;
  logic    res_valid;
  result_t res;
  logic    skid_valid;
  result_t skid;

  assign item_stall = skid_valid;
  assign take       = item_valid && !item_stall;

  ltcc_walk #(
    .PARENT_LIMIT(PARENT_LIMIT),
    .DEPTH_BITS  (DEPTH_BITS)
  ) u_walk (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .item     (item),
    .res_valid(res_valid),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (!result_valid || !result_stall) begin
      if (skid_valid) begin
        result_valid <= 1'b1;
        skid_valid   <= 1'b0;
      end else begin
        result_valid <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!result_valid || !result_stall) begin
      result <= skid_valid ? skid : res;
    end else if (res_valid) begin
      skid <= res;
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> result_valid)
    else $error("skid holds a verdict ahead of the output register");
  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    res_valid && result_valid && result_stall |=> skid_valid)
    else $error("verdict lost while output stalled");
  a_verdict_shows: assert property (@(posedge clk) disable iff (rst)
    res_valid && !result_valid |=> result_valid && $past(res) == result)
    else $error("verdict not registered");

endmodule

// File: verif/link_target_containment_check_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// link_target_containment_check_test
// Drives entry paths and link targets into the containment check and compares
// every verdict against a cycle-free model of the directory walk. Short
// directed pairs first, then randomised well-formed pairs mixed with noise
// and a back-pressure episode, and finally a stretch of pairs with no idling.
// ----------------------------------------------------------------------------
module link_target_containment_check_test;
  import ltcc_pkg::*;

  class verdict_tracker;
    localparam int LIMIT = PARENT_LIMIT_DEF;

    result_t verdicts_due[$];
    int      fails;

    bit                        in_tgt;
    bit                        tgt_started;
    bit                        tgt_abs;
    logic [1:0]                cls;
    logic [DEPTH_BITS_DEF-1:0] walk_depth;
    bit                        escaped;
    bit                        bslash;
    int                        entry_len;
    bit                        too_long;

    function new();
      fails = 0;
      clear();
    endfunction

    function void clear();
      in_tgt      = 1'b0;
      tgt_started = 1'b0;
      tgt_abs     = 1'b0;
      cls         = CLS_EMPTY;
      walk_depth  = '0;
      escaped     = 1'b0;
      bslash      = 1'b0;
      entry_len   = 0;
      too_long    = 1'b0;
    endfunction

    function void close_component();
      if (cls == CLS_DOTDOT) begin
        if (walk_depth == 0) escaped = 1'b1;
        else walk_depth--;
      end else if (cls == CLS_OTHER) begin
        if (walk_depth != '1) walk_depth++;
      end
      cls = CLS_EMPTY;
    endfunction

    function void grow_component(logic [7:0] c);
      if (c == CH_DOT && cls == CLS_EMPTY) cls = CLS_DOT;
      else if (c == CH_DOT && cls == CLS_DOT) cls = CLS_DOTDOT;
      else cls = CLS_OTHER;
    endfunction

    // the last component of the entry path names the link itself
    function void start_target();
      if (!in_tgt) begin
        in_tgt = 1'b1;
        cls    = CLS_EMPTY;
      end
    endfunction

    function void take_item(item_t it);
      result_t v;
      case (it.mode)
        MODE_ENTRY_CHAR: begin
          if (!in_tgt) begin
            if (it.ch == CH_SLASH) begin
              if (entry_len >= LIMIT) too_long = 1'b1;
              close_component();
            end else begin
              grow_component(it.ch);
            end
            if (entry_len < LIMIT) entry_len++;
          end
        end
        MODE_ENTRY_END: start_target();
        MODE_TGT_CHAR: begin
          start_target();
          if (!tgt_started && it.ch == CH_SLASH) begin
            // absolute target: judged alone from the root
            tgt_started = 1'b1;
            tgt_abs     = 1'b1;
            walk_depth  = '0;
            escaped     = 1'b0;
          end else begin
            tgt_started = 1'b1;
            if (it.ch == CH_BACKSLASH) bslash = 1'b1;
            if (it.ch == CH_SLASH) close_component();
            else grow_component(it.ch);
          end
        end
        default: begin
          start_target();
          close_component();
          if (!tgt_started) v.reason = RSN_EMPTY;
          else if (bslash) v.reason = RSN_BACKSLASH;
          else if (!tgt_abs && too_long) v.reason = RSN_TOO_LONG;
          else if (escaped) v.reason = RSN_ESCAPE;
          else v.reason = RSN_OK;
          v.accepted = (v.reason == RSN_OK);
          verdicts_due.push_back(v);
          clear();
        end
      endcase
    endfunction

    function void check_verdict(result_t got);
      result_t want;
      if (verdicts_due.size() == 0) begin
        $error("verdict with none due: accepted %0d reason %0d", got.accepted, got.reason);
        fails++;
        return;
      end
      want = verdicts_due.pop_front();
      if (got.accepted !== want.accepted) begin
        $error("accepted: expected %0d, got %0d", want.accepted, got.accepted);
        fails++;
      end
      if (got.reason !== want.reason) begin
        $error("reason: expected %0d, got %0d", want.reason, got.reason);
        fails++;
      end
    endfunction
  endclass

  localparam int RANDOM_ITEMS = 940;
  localparam int CALM_ITEMS   = 80;
  localparam int HOLD_CYCLES  = 80;

  logic    clk          = 1'b0;
  logic    rst          = 1'b1;
  logic    item_valid   = 1'b0;
  logic    item_stall;
  item_t   item         = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;

  bit calm     = 1'b0;
  bit hold_req = 1'b0;
  int sent     = 0;

  verdict_tracker board = new();

  link_target_containment_check uut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always #5 clk = ~clk;

  // both channels observed in one process so prediction always precedes checking
  always @(posedge clk) begin
    if (!rst) begin
      if (item_valid && !item_stall) board.take_item(item);
      if (result_valid && !result_stall) board.check_verdict(result);
    end
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        result_stall <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 11);
        result_stall <= 1'b1;
        repeat (n) @(posedge clk);
        result_stall <= 1'b0;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

  task automatic send(input logic [1:0] m, input logic [7:0] c);
    int gap;
    if (!calm && $urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 11);
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= '{mode: m, ch: c};
    @(posedge clk);
    while (item_stall) @(posedge clk);
    sent++;
  endtask

  task automatic send_text(input logic [1:0] m, input string s);
    for (int i = 0; i < s.len(); i++) send(m, s[i]);
  endtask

  task automatic send_path(input logic [1:0] m);
    int         parts;
    int         len;
    logic [7:0] b;
    if ($urandom_range(0, 3) == 0) send(m, CH_SLASH);
    parts = $urandom_range(0, 5);
    for (int i = 0; i < parts; i++) begin
      if (i > 0) send(m, CH_SLASH);
      case ($urandom_range(0, 6))
        0: ;
        1, 2, 3: begin
          len = $urandom_range(1, 3);
          repeat (len) send(m, CH_DOT);
        end
        default: begin
          len = $urandom_range(1, 4);
          for (int j = 0; j < len; j++) begin
            case ($urandom_range(0, 29))
              0, 1, 2: b = 8'($urandom_range(0, 255));
              3:       b = CH_BACKSLASH;
              4:       b = CH_DOT;
              default: b = 8'h61 + 8'($urandom_range(0, 25));
            endcase
            send(m, b);
          end
        end
      endcase
    end
    if ($urandom_range(0, 2) == 0) send(m, CH_SLASH);
  endtask

  task automatic send_pair();
    int r;
    send_path(MODE_ENTRY_CHAR);
    r = $urandom_range(0, 19);
    if (r >= 2) send(MODE_ENTRY_END, 8'($urandom_range(0, 255)));
    if (r == 19) send(MODE_ENTRY_END, 8'($urandom_range(0, 255)));
    if (r == 18) send(MODE_ENTRY_CHAR, 8'($urandom_range(0, 255)));
    if ($urandom_range(0, 15) != 0) send_path(MODE_TGT_CHAR);
    send(MODE_TGT_END, 8'($urandom_range(0, 255)));
  endtask

  initial begin
    int  base;
    int  waited;
    bit  pressed;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed
    send(MODE_TGT_END, 8'h00);
    send_text(MODE_ENTRY_CHAR, "../");
    send_text(MODE_TGT_CHAR, "a");
    send(MODE_TGT_END, 8'hff);
    send_text(MODE_ENTRY_CHAR, "../");
    send(MODE_ENTRY_END, 8'hff);
    send(MODE_ENTRY_END, 8'h00);
    send(MODE_ENTRY_CHAR, "z");
    send_text(MODE_TGT_CHAR, "/.");
    send(MODE_TGT_END, 8'h00);
    send_text(MODE_TGT_CHAR, "a\\");
    send(MODE_TGT_END, 8'h00);
    send(MODE_ENTRY_CHAR, 8'h00);
    send(MODE_ENTRY_CHAR, CH_SLASH);
    send_text(MODE_TGT_CHAR, "..");
    send(MODE_TGT_END, 8'h00);
    send(MODE_ENTRY_CHAR, 8'hff);
    send(MODE_ENTRY_CHAR, CH_BACKSLASH);
    send(MODE_ENTRY_CHAR, CH_SLASH);
    send(MODE_ENTRY_END, 8'h00);
    send_text(MODE_TGT_CHAR, "../..");
    send(MODE_TGT_END, 8'h00);

    // random pairs with some noise; one back-pressure episode midway
    base    = sent;
    pressed = 1'b0;
    while (sent - base < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0)
        repeat ($urandom_range(1, 4))
          send(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      send_pair();
      if (!pressed && sent - base >= RANDOM_ITEMS / 2) begin
        pressed  = 1'b1;
        hold_req = 1'b1;
        repeat (30) begin
          send(MODE_TGT_CHAR, "x");
          send(MODE_TGT_END, 8'($urandom_range(0, 255)));
        end
        // sender quiet until every verdict has drained
        item_valid <= 1'b0;
        @(posedge clk);
        while (board.verdicts_due.size() != 0) @(posedge clk);
      end
    end

    // no idling from here on
    calm = 1'b1;
    base = sent;
    while (sent - base < CALM_ITEMS) send_pair();

    item_valid <= 1'b0;
    waited = 0;
    while (board.verdicts_due.size() != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    repeat (20) @(posedge clk);
    if (board.verdicts_due.size() != 0) begin
      $error("%0d verdicts never arrived", board.verdicts_due.size());
      board.fails++;
    end
    if (board.fails == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule
